// ===== rtl/core/sd_data_block_receiver_unit_assert.svh =====
// Assertion macros for the SD data block receiver.
// All checks are clocked on clk_i and held off while rst_ni is low.
`ifndef SD_DATA_BLOCK_RECEIVER_UNIT_ASSERT_SVH
`define SD_DATA_BLOCK_RECEIVER_UNIT_ASSERT_SVH

// Same-cycle implication
`define SDBR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sdbr: same-cycle check failed");

// Next-cycle implication
`define SDBR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sdbr: next-cycle check failed");

`endif

// ===== rtl/core/sdbr_pkg.sv =====
// ----------------------------------------------------------------------------
// sdbr_pkg
// Shared widths, codes and types for the SD data block receiver.
// ----------------------------------------------------------------------------
package sdbr_pkg;

  localparam int BYTE_W    = 8;
  localparam int BLK_LEN_W = 10;
  localparam int TRIES_W   = 16;
  localparam int CRC_W     = 16;
  localparam int STATUS_W  = 2;
  localparam int PHASE_W   = 3;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam int MAX_BLOCK_BYTES_DEF = 512;

  localparam logic [BLK_LEN_W-1:0] BLOCK_LENGTH_RST = 10'd512;
  localparam logic [TRIES_W-1:0]   TOKEN_TRIES_RST  = 16'd20000;

  localparam logic [BYTE_W-1:0] START_TOKEN = 8'hFE;
  localparam logic [CRC_W-1:0]  CRC_POLY    = 16'h1021;

  // register index, taken from paddr[2]
  localparam logic REG_BLOCK_LENGTH = 1'b0;
  localparam logic REG_TOKEN_TRIES  = 1'b1;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_BYTE  = 1'b1;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CRC     = 2'd2;

  localparam logic [PHASE_W-1:0] PH_IDLE = 3'd0;
  localparam logic [PHASE_W-1:0] PH_WAIT = 3'd1;
  localparam logic [PHASE_W-1:0] PH_DATA = 3'd2;
  localparam logic [PHASE_W-1:0] PH_CRCH = 3'd3;
  localparam logic [PHASE_W-1:0] PH_CRCL = 3'd4;

  typedef struct packed {
    logic [BLK_LEN_W-1:0] block_length;
    logic [TRIES_W-1:0]   token_tries;
  } cfg_t;

endpackage

// ===== rtl/core/sd_data_block_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// sd_data_block_receiver_unit - SD SPI data block receiver with CRC-16 check
// Input reg, then result reg; one transaction a cycle unless the result stalls.
// Rate is set by the combinational byte CRC update between input and result regs.
// Async active-low reset: idle, no pending result, registers at defaults.
// ----------------------------------------------------------------------------
module sd_data_block_receiver_unit #(
  parameter int MAX_BLOCK_BYTES = sdbr_pkg::MAX_BLOCK_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           req_type_i,
  input  logic [sdbr_pkg::BYTE_W-1:0]    rx_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           kind_o,
  output logic [sdbr_pkg::BYTE_W-1:0]    data_byte_o,
  output logic [sdbr_pkg::STATUS_W-1:0]  status_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sdbr_pkg::PADDR_W-1:0]   paddr,
  input  logic [sdbr_pkg::PDATA_W-1:0]   pwdata,
  output logic [sdbr_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  sdbr_pkg::cfg_t cfg;

  sdbr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sdbr_core #(
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .data_byte_o (data_byte_o),
    .status_o    (status_o)
  );

endmodule

// ===== rtl/core/sdbr_cfg.sv =====
// ----------------------------------------------------------------------------
// sdbr_cfg
// APB register file: block length and token try limit.
// ----------------------------------------------------------------------------
module sdbr_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sdbr_pkg::PADDR_W-1:0]  paddr,
  input  logic [sdbr_pkg::PDATA_W-1:0]  pwdata,
  output logic [sdbr_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output sdbr_pkg::cfg_t                cfg_o
);

  logic [sdbr_pkg::BLK_LEN_W-1:0] block_length_q, block_length_d;
  logic [sdbr_pkg::TRIES_W-1:0]   token_tries_q, token_tries_d;
  logic                           wr_en;
  logic                           reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  always_comb begin
    block_length_d = block_length_q;
    token_tries_d  = token_tries_q;
    if (wr_en) begin
      case (reg_sel)
        sdbr_pkg::REG_BLOCK_LENGTH: block_length_d = pwdata[sdbr_pkg::BLK_LEN_W-1:0];
        sdbr_pkg::REG_TOKEN_TRIES:  token_tries_d  = pwdata[sdbr_pkg::TRIES_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_length_q <= sdbr_pkg::BLOCK_LENGTH_RST;
      token_tries_q  <= sdbr_pkg::TOKEN_TRIES_RST;
    end else begin
      block_length_q <= block_length_d;
      token_tries_q  <= token_tries_d;
    end
  end

  always_comb begin
    case (reg_sel)
      sdbr_pkg::REG_BLOCK_LENGTH:
        prdata = sdbr_pkg::PDATA_W'(block_length_q);
      sdbr_pkg::REG_TOKEN_TRIES:
        prdata = sdbr_pkg::PDATA_W'(token_tries_q);
      default:
        prdata = '0;
    endcase
  end

  assign cfg_o.block_length = block_length_q;
  assign cfg_o.token_tries  = token_tries_q;

endmodule

// ===== rtl/core/sdbr_crc16.sv =====
// ----------------------------------------------------------------------------
// sdbr_crc16
// Byte-wide CRC-16-CCITT update, polynomial 0x1021, MSB first.
// ----------------------------------------------------------------------------
module sdbr_crc16 (
  input  logic [sdbr_pkg::CRC_W-1:0]  crc_i,
  input  logic [sdbr_pkg::BYTE_W-1:0] byte_i,
  output logic [sdbr_pkg::CRC_W-1:0]  crc_o
);

  always_comb begin
    logic [sdbr_pkg::CRC_W-1:0] c;
    c = crc_i ^ {byte_i, {(sdbr_pkg::CRC_W-sdbr_pkg::BYTE_W){1'b0}}};
    for (int i = 0; i < sdbr_pkg::BYTE_W; i++) begin
      if (c[sdbr_pkg::CRC_W-1]) begin
        c = {c[sdbr_pkg::CRC_W-2:0], 1'b0} ^ sdbr_pkg::CRC_POLY;
      end else begin
        c = {c[sdbr_pkg::CRC_W-2:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule

// ===== rtl/core/sdbr_core.sv =====
// ----------------------------------------------------------------------------
// sdbr_core
// Input register, block receive state machine and result register.
// ----------------------------------------------------------------------------
`include "sd_data_block_receiver_unit_assert.svh"

module sdbr_core #(
  parameter int MAX_BLOCK_BYTES = sdbr_pkg::MAX_BLOCK_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sdbr_pkg::cfg_t                 cfg_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           req_type_i,
  input  logic [sdbr_pkg::BYTE_W-1:0]    rx_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           kind_o,
  output logic [sdbr_pkg::BYTE_W-1:0]    data_byte_o,
  output logic [sdbr_pkg::STATUS_W-1:0]  status_o
);

  localparam int CntW = $clog2(MAX_BLOCK_BYTES + 1);
  localparam int LenW = (CntW > sdbr_pkg::BLK_LEN_W) ? CntW : sdbr_pkg::BLK_LEN_W;

  // input register
  logic                        in_valid_q;
  logic                        req_q;
  logic [sdbr_pkg::BYTE_W-1:0] byte_q;
  logic                        adv;

  // block state
  logic [sdbr_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic [sdbr_pkg::TRIES_W-1:0] tries_q, tries_d;
  logic [CntW-1:0]              bytes_q, bytes_d;
  logic [sdbr_pkg::CRC_W-1:0]   crc_q, crc_d, crc_next;
  logic [sdbr_pkg::BYTE_W-1:0]  crc_hi_q, crc_hi_d;

  // result register
  logic                          out_valid_q, out_valid_d;
  logic                          kind_q, kind_d;
  logic [sdbr_pkg::BYTE_W-1:0]   data_q, data_d;
  logic [sdbr_pkg::STATUS_W-1:0] status_q, status_d;

  logic                          emit;
  logic                          res_kind;
  logic [sdbr_pkg::BYTE_W-1:0]   res_data;
  logic [sdbr_pkg::STATUS_W-1:0] res_status;
  logic [LenW-1:0]               len_ext;
  logic [CntW-1:0]               len_c;

  assign adv        = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q  <= req_type_i;
      byte_q <= rx_byte_i;
    end
  end

  sdbr_crc16 u_crc (
    .crc_i  (crc_q),
    .byte_i (byte_q),
    .crc_o  (crc_next)
  );

  // block length clamped to 1..MAX_BLOCK_BYTES
  always_comb begin
    len_ext = LenW'(cfg_i.block_length);
    if (len_ext == '0) begin
      len_ext = LenW'(1);
    end else if (len_ext > LenW'(MAX_BLOCK_BYTES)) begin
      len_ext = LenW'(MAX_BLOCK_BYTES);
    end
    len_c = len_ext[CntW-1:0];
  end

  always_comb begin
    phase_d    = phase_q;
    tries_d    = tries_q;
    bytes_d    = bytes_q;
    crc_d      = crc_q;
    crc_hi_d   = crc_hi_q;
    emit       = 1'b0;
    res_kind   = sdbr_pkg::KIND_DATA;
    res_data   = '0;
    res_status = sdbr_pkg::ST_OK;
    if (adv) begin
      if (req_q == sdbr_pkg::REQ_START) begin
        tries_d  = cfg_i.token_tries;
        bytes_d  = len_c;
        crc_d    = '0;
        crc_hi_d = '0;
        phase_d  = sdbr_pkg::PH_WAIT;
      end else begin
        case (phase_q)
          sdbr_pkg::PH_WAIT: begin
            if (byte_q == sdbr_pkg::START_TOKEN) begin
              phase_d = sdbr_pkg::PH_DATA;
            end else if (tries_q <= sdbr_pkg::TRIES_W'(1)) begin
              tries_d    = '0;
              phase_d    = sdbr_pkg::PH_IDLE;
              emit       = 1'b1;
              res_kind   = sdbr_pkg::KIND_STATUS;
              res_status = sdbr_pkg::ST_TIMEOUT;
            end else begin
              tries_d = tries_q - sdbr_pkg::TRIES_W'(1);
            end
          end
          sdbr_pkg::PH_DATA: begin
            crc_d = crc_next;
            if (bytes_q <= CntW'(1)) begin
              bytes_d = '0;
              phase_d = sdbr_pkg::PH_CRCH;
            end else begin
              bytes_d = bytes_q - CntW'(1);
            end
            emit     = 1'b1;
            res_kind = sdbr_pkg::KIND_DATA;
            res_data = byte_q;
          end
          sdbr_pkg::PH_CRCH: begin
            crc_hi_d = byte_q;
            phase_d  = sdbr_pkg::PH_CRCL;
          end
          sdbr_pkg::PH_CRCL: begin
            phase_d  = sdbr_pkg::PH_IDLE;
            emit     = 1'b1;
            res_kind = sdbr_pkg::KIND_STATUS;
            if ({crc_hi_q, byte_q} == crc_q) begin
              res_status = sdbr_pkg::ST_OK;
            end else begin
              res_status = sdbr_pkg::ST_CRC;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    data_d      = data_q;
    status_d    = status_q;
    if (adv) begin
      out_valid_d = emit;
      if (emit) begin
        kind_d   = res_kind;
        data_d   = res_data;
        status_d = res_status;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= sdbr_pkg::PH_IDLE;
      tries_q     <= '0;
      bytes_q     <= '0;
      crc_q       <= '0;
      crc_hi_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      tries_q     <= tries_d;
      bytes_q     <= bytes_d;
      crc_q       <= crc_d;
      crc_hi_q    <= crc_hi_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    data_q   <= data_d;
    status_q <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign data_byte_o = data_q;
  assign status_o    = status_q;

  `SDBR_ASSERT_NEXT(a_start_arms, adv && req_q == sdbr_pkg::REQ_START,
                    phase_q == sdbr_pkg::PH_WAIT && crc_q == '0)
  `SDBR_ASSERT_NEXT(a_silent_item_no_result, adv && !emit, !out_valid_q)
  `SDBR_ASSERT_NOW(a_data_phase_count, phase_q == sdbr_pkg::PH_DATA, bytes_q != '0)
  `SDBR_ASSERT_NOW(a_status_zero_byte, out_valid_q && kind_q == sdbr_pkg::KIND_STATUS,
                   data_q == '0)

endmodule

// ===== tb/sd_data_block_receiver_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SD data block receiver - transaction checker
// Watches the byte, result and register ports, tracks the receive state of
// the block from every accepted start or byte transaction, and compares each
// accepted result with the oldest expected one. Mismatches are counted.
// ----------------------------------------------------------------------------
module sd_data_block_receiver_checker #(
  parameter int MAX_BLOCK_BYTES = sdbr_pkg::MAX_BLOCK_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic                          req_type_i,
  input  logic [sdbr_pkg::BYTE_W-1:0]   rx_byte_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic                          kind_i,
  input  logic [sdbr_pkg::BYTE_W-1:0]   data_byte_i,
  input  logic [sdbr_pkg::STATUS_W-1:0] status_i,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [sdbr_pkg::PADDR_W-1:0]  paddr_i,
  input  logic [sdbr_pkg::PDATA_W-1:0]  pwdata_i,
  input  logic                          pready_i,
  output int                            fail_cnt_o,
  output int                            pending_cnt_o
);

  typedef struct packed {
    logic                          kind;
    logic [sdbr_pkg::BYTE_W-1:0]   data;
    logic [sdbr_pkg::STATUS_W-1:0] status;
  } blk_result_t;

  blk_result_t                    blk_results_q[$];
  blk_result_t                    got;
  blk_result_t                    want;
  sdbr_pkg::cfg_t                 cfg;
  logic [sdbr_pkg::PHASE_W-1:0]   rx_state;
  logic [sdbr_pkg::TRIES_W-1:0]   token_budget;
  logic [sdbr_pkg::BLK_LEN_W-1:0] data_to_go;
  logic [sdbr_pkg::CRC_W-1:0]     crc_run;
  logic [sdbr_pkg::BYTE_W-1:0]    crc_hi_rx;
  int                             n_bad = 0;

  // CRC-16-CCITT, MSB first, one byte
  function automatic logic [sdbr_pkg::CRC_W-1:0] crc16_ccitt_byte(
    input logic [sdbr_pkg::CRC_W-1:0]  c,
    input logic [sdbr_pkg::BYTE_W-1:0] b);
    logic [sdbr_pkg::CRC_W-1:0] x;
    x = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      x = x[sdbr_pkg::CRC_W-1] ? ((x << 1) ^ sdbr_pkg::CRC_POLY) : (x << 1);
    end
    return x;
  endfunction

  task automatic expect_result(input logic k, input logic [sdbr_pkg::BYTE_W-1:0] d,
                               input logic [sdbr_pkg::STATUS_W-1:0] s);
    blk_result_t r;
    r.kind   = k;
    r.data   = d;
    r.status = s;
    blk_results_q.push_back(r);
  endtask

  task automatic take_rx_item(input logic req, input logic [sdbr_pkg::BYTE_W-1:0] b);
    if (req == sdbr_pkg::REQ_START) begin
      if (cfg.block_length == '0) data_to_go = sdbr_pkg::BLK_LEN_W'(1);
      else if (cfg.block_length > MAX_BLOCK_BYTES)
        data_to_go = sdbr_pkg::BLK_LEN_W'(MAX_BLOCK_BYTES);
      else data_to_go = cfg.block_length;
      token_budget = cfg.token_tries;
      crc_run      = '0;
      crc_hi_rx    = '0;
      rx_state     = sdbr_pkg::PH_WAIT;
    end else begin
      case (rx_state)
        sdbr_pkg::PH_WAIT: begin
          if (b == sdbr_pkg::START_TOKEN) begin
            rx_state = sdbr_pkg::PH_DATA;
          end else if (token_budget <= 1) begin
            token_budget = '0;
            rx_state     = sdbr_pkg::PH_IDLE;
            expect_result(sdbr_pkg::KIND_STATUS, '0, sdbr_pkg::ST_TIMEOUT);
          end else begin
            token_budget = token_budget - 1'b1;
          end
        end
        sdbr_pkg::PH_DATA: begin
          crc_run = crc16_ccitt_byte(crc_run, b);
          if (data_to_go <= 1) begin
            data_to_go = '0;
            rx_state   = sdbr_pkg::PH_CRCH;
          end else begin
            data_to_go = data_to_go - 1'b1;
          end
          expect_result(sdbr_pkg::KIND_DATA, b, sdbr_pkg::ST_OK);
        end
        sdbr_pkg::PH_CRCH: begin
          crc_hi_rx = b;
          rx_state  = sdbr_pkg::PH_CRCL;
        end
        sdbr_pkg::PH_CRCL: begin
          rx_state = sdbr_pkg::PH_IDLE;
          if ({crc_hi_rx, b} == crc_run)
            expect_result(sdbr_pkg::KIND_STATUS, '0, sdbr_pkg::ST_OK);
          else expect_result(sdbr_pkg::KIND_STATUS, '0, sdbr_pkg::ST_CRC);
        end
        default: ;
      endcase
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.block_length = sdbr_pkg::BLOCK_LENGTH_RST;
      cfg.token_tries  = sdbr_pkg::TOKEN_TRIES_RST;
      rx_state         = sdbr_pkg::PH_IDLE;
      token_budget     = '0;
      data_to_go       = '0;
      crc_run          = '0;
      crc_hi_rx        = '0;
      blk_results_q.delete();
      pending_cnt_o   <= 0;
    end else begin
      // results first, so a result never matches an expectation of the same edge
      if (out_valid_i && out_ready_i) begin
        got.kind   = kind_i;
        got.data   = data_byte_i;
        got.status = status_i;
        if (blk_results_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("%0t: unexpected result kind=%0d data=%02h status=%0d",
                     $realtime, got.kind, got.data, got.status);
        end else begin
          want = blk_results_q.pop_front();
          if (got !== want) begin
            n_bad++;
            if (n_bad <= 10)
              $display("%0t: result mismatch, expected kind=%0d data=%02h status=%0d, %s",
                       $realtime, want.kind, want.data, want.status,
                       $sformatf("got kind=%0d data=%02h status=%0d",
                                 got.kind, got.data, got.status));
          end
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == sdbr_pkg::REG_BLOCK_LENGTH)
          cfg.block_length = pwdata_i[sdbr_pkg::BLK_LEN_W-1:0];
        else cfg.token_tries = pwdata_i[sdbr_pkg::TRIES_W-1:0];
      end
      if (in_valid_i && in_ready_i) take_rx_item(req_type_i, rx_byte_i);
      pending_cnt_o <= blk_results_q.size();
      fail_cnt_o    <= n_bad;
    end
  end

endmodule

// ===== tb/tb_sd_data_block_receiver_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SD data block receiver - testbench top
// Drives start and byte transactions with random gaps and result back-pressure
// through several register settings: directed corner blocks first, then random
// well-formed, corrupted, aborted and timed-out blocks. Checking is done by the
// checker instance; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_sd_data_block_receiver_unit;

  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 4000;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  logic                          req_type_i  = sdbr_pkg::REQ_START;
  logic [sdbr_pkg::BYTE_W-1:0]   rx_byte_i   = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic                          kind_o;
  logic [sdbr_pkg::BYTE_W-1:0]   data_byte_o;
  logic [sdbr_pkg::STATUS_W-1:0] status_o;
  logic                          psel        = 1'b0;
  logic                          penable     = 1'b0;
  logic                          pwrite      = 1'b0;
  logic [sdbr_pkg::PADDR_W-1:0]  paddr       = '0;
  logic [sdbr_pkg::PDATA_W-1:0]  pwdata      = '0;
  logic [sdbr_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;

  int                            fail_cnt;
  int                            pending_cnt;
  int                            items_sent = 0;
  int                            quiet_cycles = 0;
  int                            blk_len_eff = 512;
  int                            tries_eff = 20000;
  bit                            gap_on = 1'b0;
  bit                            stall_on = 1'b0;
  bit                            no_idle = 1'b0;
  bit                            hold_req = 1'b0;
  logic [sdbr_pkg::BYTE_W-1:0]   block_bytes[$];

  always #1 clk_i = ~clk_i;

  sd_data_block_receiver_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (req_type_i),
    .rx_byte_i  (rx_byte_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .kind_o     (kind_o),
    .data_byte_o(data_byte_o),
    .status_o   (status_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  sd_data_block_receiver_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .req_type_i   (req_type_i),
    .rx_byte_i    (rx_byte_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_i       (kind_o),
    .data_byte_i  (data_byte_o),
    .status_i     (status_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fail_cnt_o   (fail_cnt),
    .pending_cnt_o(pending_cnt)
  );

  // result side: random stalls, plus one long hold-off on request
  initial begin
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_item(input logic req, input logic [sdbr_pkg::BYTE_W-1:0] b);
    if (gap_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent = items_sent + 1;
  endtask

  function automatic logic [sdbr_pkg::BYTE_W-1:0] non_token_byte();
    logic [sdbr_pkg::BYTE_W-1:0] b;
    b = sdbr_pkg::BYTE_W'($urandom);
    return (b == sdbr_pkg::START_TOKEN) ? 8'hFF : b;
  endfunction

  // start, optional non-token bytes, token, payload, CRC; cut < 0 sends it all
  task automatic send_block(input int n_noise, input bit bad_crc, input int cut);
    logic [sdbr_pkg::CRC_W-1:0]  crc;
    logic [sdbr_pkg::BYTE_W-1:0] b;
    crc = '0;
    block_bytes.delete();
    repeat (n_noise) block_bytes.push_back(non_token_byte());
    block_bytes.push_back(sdbr_pkg::START_TOKEN);
    repeat (blk_len_eff) begin
      b   = sdbr_pkg::BYTE_W'($urandom);
      crc = u_chk.crc16_ccitt_byte(crc, b);
      block_bytes.push_back(b);
    end
    if (bad_crc) crc = crc ^ sdbr_pkg::CRC_W'($urandom_range(1, 65535));
    block_bytes.push_back(crc[15:8]);
    block_bytes.push_back(crc[7:0]);
    send_item(sdbr_pkg::REQ_START, sdbr_pkg::BYTE_W'($urandom));
    foreach (block_bytes[i])
      if (cut < 0 || i < cut) send_item(sdbr_pkg::REQ_BYTE, block_bytes[i]);
  endtask

  task automatic send_timeout();
    send_item(sdbr_pkg::REQ_START, sdbr_pkg::BYTE_W'($urandom));
    repeat (tries_eff) send_item(sdbr_pkg::REQ_BYTE, non_token_byte());
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending_cnt == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [sdbr_pkg::PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_cfg(input int len, input int tries);
    drain_results();
    write_reg(sdbr_pkg::REG_BLOCK_LENGTH, len);
    write_reg(sdbr_pkg::REG_TOKEN_TRIES, tries);
    if (len == 0) blk_len_eff = 1;
    else if (len > sdbr_pkg::MAX_BLOCK_BYTES_DEF) blk_len_eff = sdbr_pkg::MAX_BLOCK_BYTES_DEF;
    else blk_len_eff = len;
    tries_eff = (tries == 0) ? 1 : tries;
  endtask

  task automatic run_phase(input int upto);
    int pick;
    int noise_max;
    noise_max = (tries_eff > 6) ? 6 : tries_eff - 1;
    while (items_sent < upto) begin
      gap_on   = !no_idle && $urandom_range(0, 3) != 0;
      stall_on = !no_idle && $urandom_range(0, 3) != 0;
      pick     = $urandom_range(0, 99);
      if (pick < 60) begin
        send_block($urandom_range(0, noise_max), 1'b0, -1);
      end else if (pick < 72) begin
        send_block($urandom_range(0, noise_max), 1'b1, -1);
      end else if (pick < 80 && tries_eff <= 16) begin
        send_timeout();
      end else if (pick < 88) begin
        send_block($urandom_range(0, noise_max), 1'($urandom_range(0, 1)),
                   $urandom_range(0, noise_max + blk_len_eff + 3));
      end else if (pick < 94) begin
        repeat ($urandom_range(1, 3))
          send_item(sdbr_pkg::REQ_BYTE, sdbr_pkg::BYTE_W'($urandom));
      end else begin
        send_item(sdbr_pkg::REQ_START, sdbr_pkg::BYTE_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero length and zero tries act as one
    write_cfg(0, 0);
    send_item(sdbr_pkg::REQ_BYTE, sdbr_pkg::START_TOKEN);
    send_block(0, 1'b0, -1);
    send_item(sdbr_pkg::REQ_START, 8'hFF);
    send_item(sdbr_pkg::REQ_BYTE, 8'h00);
    send_item(sdbr_pkg::REQ_START, 8'h00);
    send_block(0, 1'b1, -1);
    send_block(0, 1'b0, 2);
    send_block(0, 1'b0, 3);
    send_block(0, 1'b0, -1);
    // token on the last allowed try
    write_cfg(2, 3);
    send_block(2, 1'b0, -1);

    write_cfg(1, 1);
    run_phase(180);
    write_cfg(3, 5);
    run_phase(400);
    write_cfg(16, 65535);
    run_phase(620);
    write_cfg(8, 2);
    run_phase(780);

    // saturated length; results held back so the input backs up
    write_cfg(1023, 4);
    gap_on   = 1'b0;
    stall_on = 1'b0;
    hold_req = 1'b1;
    send_block(2, 1'b0, -1);

    write_cfg(5, 7);
    no_idle = 1'b1;
    run_phase(1420);
    drain_results();

    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/sdbr_pkg.sv
rtl/core/sdbr_cfg.sv
rtl/core/sdbr_crc16.sv
rtl/core/sdbr_core.sv
rtl/core/sd_data_block_receiver_unit.sv
tb/sd_data_block_receiver_checker.sv
tb/tb_sd_data_block_receiver_unit.sv
